[design/dse_pkg.sv]
package dse_pkg;

  localparam int BUFFER_DEPTH    = 64;
  localparam int MIN_UPDATE_MS   = 12;
  localparam int STORE_PERIOD_MS = 10;
  localparam int MAX_LOOKUP_MS   = 200;
  localparam int MS_PER_S        = 1000;

  localparam int TIME_W     = 32;
  localparam int ALT_W      = 32;
  localparam int NOISE_W    = 16;
  localparam int DRIFT_W    = 12;
  localparam int AMP_W      = 16;
  localparam int DELAY_W    = 16;
  localparam int DIST_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ALT_W-1:0] ALT_MAX = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_PRESENT  = 3'd0,
    REG_DISABLE         = 3'd1,
    REG_DRIFT_RATE      = 3'd2,
    REG_NOISE_AMPLITUDE = 3'd3,
    REG_GLITCH_OFFSET   = 3'd4,
    REG_DELAY_MS        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DRIFT_W-1:0] drift_rate;
    logic        [AMP_W-1:0]   noise_amplitude;
    logic signed [ALT_W-1:0]   glitch_offset;
  } calc_cfg_t;

  typedef struct packed {
    logic             done;
    logic [ALT_W-1:0] value;
  } calc_res_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic             is_new;
    logic [ALT_W-1:0] alt;
  } srch_res_t;

endpackage

[design/dse_if.sv]
interface dse_meas_if;
  logic                                 valid;
  logic                                 ready;
  logic        [dse_pkg::TIME_W-1:0]    now_ms;
  logic signed [dse_pkg::ALT_W-1:0]     true_altitude;
  logic signed [dse_pkg::NOISE_W-1:0]   noise_sample;

  modport source (output valid, output now_ms, output true_altitude, output noise_sample,
                  input ready);
  modport sink (input valid, input now_ms, input true_altitude, input noise_sample,
                output ready);
endinterface

interface dse_report_if;
  logic                             valid;
  logic                             ready;
  logic signed [dse_pkg::ALT_W-1:0] reported_altitude;

  modport source (output valid, output reported_altitude, input ready);
  modport sink (input valid, input reported_altitude, output ready);
endinterface

[design/dse_calc.sv]
module dse_calc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  dse_pkg::calc_cfg_t                  cfg,
  input  logic        [dse_pkg::TIME_W-1:0]   now,
  input  logic signed [dse_pkg::ALT_W-1:0]    alt,
  input  logic signed [dse_pkg::NOISE_W-1:0]  noise,
  output dse_pkg::calc_res_t                  res
);

  localparam int TW      = dse_pkg::TIME_W;
  localparam int MAGIC_W = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
  localparam int DIV_SH  = 38;
  localparam int MP_W    = TW + MAGIC_W;
  localparam int QT_W    = 23;
  localparam int RT_W    = $clog2(dse_pkg::MS_PER_S);
  localparam int HI_W    = dse_pkg::DRIFT_W + QT_W;
  localparam int PL_W    = dse_pkg::DRIFT_W + RT_W;
  localparam int LO_W    = dse_pkg::DRIFT_W;
  localparam int DR_W    = HI_W + 1;
  localparam int NP_W    = dse_pkg::AMP_W + dse_pkg::NOISE_W + 1;
  localparam int NQ_W    = NP_W - (dse_pkg::NOISE_W - 1);
  localparam int BASE_W  = dse_pkg::ALT_W + 1;
  localparam int SUM_W   = DR_W + 1;

  typedef enum logic [7:0] {
    C_IDLE = 8'b0000_0001,
    C_QT   = 8'b0000_0010,
    C_RM   = 8'b0000_0100,
    C_LP   = 8'b0000_1000,
    C_LD   = 8'b0001_0000,
    C_DR   = 8'b0010_0000,
    C_SUM  = 8'b0100_0000,
    C_SAT  = 8'b1000_0000
  } cstate_t;

  cstate_t                     state;
  logic                        done;
  logic [dse_pkg::DRIFT_W-1:0] dmag;
  logic                        neg;
  logic [QT_W-1:0]             qt;
  logic [RT_W-1:0]             rt;
  logic [HI_W-1:0]             hi;
  logic [PL_W-1:0]             pl;
  logic [LO_W-1:0]             lo;
  logic signed [DR_W-1:0]      drift;
  logic signed [NP_W-1:0]      np;
  logic signed [NQ_W-1:0]      nq;
  logic signed [BASE_W-1:0]    base;
  logic signed [SUM_W-1:0]     sum;
  logic [dse_pkg::ALT_W-1:0]   value;

  logic [dse_pkg::DRIFT_W-1:0] dr_mag;
  logic [MP_W-1:0]             qt_prod;
  logic [MP_W-1:0]             lo_prod;
  logic [TW-1:0]               rm_full;
  logic signed [DR_W-1:0]      dr_sum;
  logic signed [NP_W-1:0]      np_full;
  logic signed [NP_W-1:0]      np_adj;
  logic                        in_range;

  assign dr_mag  = cfg.drift_rate[dse_pkg::DRIFT_W-1] ?
                   dse_pkg::DRIFT_W'(-cfg.drift_rate) : cfg.drift_rate;
  assign qt_prod = MP_W'(now) * MP_W'(DIV_MAGIC);
  assign lo_prod = MP_W'(pl) * MP_W'(DIV_MAGIC);
  assign rm_full = now - (TW'(qt) * TW'(dse_pkg::MS_PER_S));
  assign dr_sum  = DR_W'(hi) + DR_W'(lo);
  assign np_full = $signed({1'b0, cfg.noise_amplitude}) * noise;
  assign np_adj  = np + (np[NP_W-1] ? NP_W'((1 << (dse_pkg::NOISE_W - 1)) - 1) : NP_W'(0));

  assign in_range = &sum[SUM_W-1:dse_pkg::ALT_W-1] || ~|sum[SUM_W-1:dse_pkg::ALT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            done  <= 1'b0;
            state <= C_QT;
          end
        end
        C_QT: begin
          state <= C_RM;
        end
        C_RM: begin
          state <= C_LP;
        end
        C_LP: begin
          state <= C_LD;
        end
        C_LD: begin
          state <= C_DR;
        end
        C_DR: begin
          state <= C_SUM;
        end
        C_SUM: begin
          state <= C_SAT;
        end
        C_SAT: begin
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        if (start) begin
          dmag <= dr_mag;
          neg  <= cfg.drift_rate[dse_pkg::DRIFT_W-1];
          np   <= np_full;
          base <= BASE_W'(alt) + BASE_W'(cfg.glitch_offset);
        end
      end
      C_QT: begin
        qt <= qt_prod[DIV_SH +: QT_W];
        nq <= np_adj[NP_W-1:dse_pkg::NOISE_W-1];
      end
      C_RM: begin
        rt <= rm_full[RT_W-1:0];
        hi <= HI_W'(dmag) * HI_W'(qt);
      end
      C_LP: begin
        pl <= PL_W'(dmag) * PL_W'(rt);
      end
      C_LD: begin
        lo <= lo_prod[DIV_SH +: LO_W];
      end
      C_DR: begin
        drift <= neg ? -dr_sum : dr_sum;
      end
      C_SUM: begin
        sum <= SUM_W'(base) + SUM_W'(drift) + SUM_W'(nq);
      end
      C_SAT: begin
        value <= in_range ? sum[dse_pkg::ALT_W-1:0] :
                 (sum[SUM_W-1] ? dse_pkg::ALT_MIN : dse_pkg::ALT_MAX);
      end
      default: begin
      end
    endcase
  end

  assign res.done  = done;
  assign res.value = value;

endmodule

[design/dse_buf.sv]
module dse_buf #(
  parameter int BUFFER_DEPTH = dse_pkg::BUFFER_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dse_pkg::TIME_W-1:0]       target,
  input  logic [dse_pkg::TIME_W-1:0]       now,
  input  logic                             store,
  input  logic [$clog2(BUFFER_DEPTH)-1:0]  w_idx,
  input  logic                             wr_en,
  input  logic [dse_pkg::ALT_W-1:0]        wr_alt,
  output dse_pkg::srch_res_t               res
);

  localparam int IW     = $clog2(BUFFER_DEPTH);
  localparam int WORD_W = dse_pkg::ALT_W + dse_pkg::TIME_W;
  localparam int TW     = dse_pkg::TIME_W;
  localparam int DW     = dse_pkg::DIST_W;

  logic [WORD_W-1:0]       mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] filled;

  logic                    scan;
  logic [IW-1:0]           cnt;
  logic                    rd_vld;
  logic [IW-1:0]           rd_idx;
  logic [WORD_W-1:0]       rd_word;
  logic                    rd_ok;

  logic [DW-1:0]           best;
  logic                    best_new;
  logic [dse_pkg::ALT_W-1:0] best_alt;
  logic                    done;

  logic                    is_new;
  logic [TW-1:0]           ts;
  logic [dse_pkg::ALT_W-1:0] ent_alt;
  logic [TW-1:0]           d;
  logic                    pos_near;
  logic                    neg_near;
  logic [DW-1:0]           mag;
  logic                    hit;

  assign is_new   = store && (rd_idx == w_idx);
  assign ts       = is_new ? now : (rd_ok ? rd_word[TW-1:0] : '0);
  assign ent_alt  = rd_ok ? rd_word[WORD_W-1:TW] : '0;
  assign d        = target - ts;
  assign pos_near = !d[TW-1] && ~|d[TW-1:DW];
  assign neg_near = d[TW-1] && &d[TW-1:DW] && |d[DW-1:0];
  assign mag      = d[TW-1] ? DW'(-d[DW-1:0]) : d[DW-1:0];
  assign hit      = rd_vld && (pos_near || neg_near) && (mag < best);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[w_idx] <= {wr_alt, now};
    end
    if (scan) begin
      rd_word <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      scan   <= 1'b0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        filled[w_idx] <= 1'b1;
      end
      rd_vld <= scan;
      if (start) begin
        scan <= 1'b1;
        cnt  <= '0;
        done <= 1'b0;
      end else if (scan) begin
        cnt <= cnt + IW'(1);
        if (cnt == IW'(BUFFER_DEPTH - 1)) begin
          scan <= 1'b0;
        end
      end
      if (rd_vld && rd_idx == IW'(BUFFER_DEPTH - 1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan) begin
      rd_idx <= cnt;
      rd_ok  <= filled[cnt];
    end
    if (start) begin
      best     <= DW'(dse_pkg::MAX_LOOKUP_MS);
      best_new <= 1'b0;
    end else if (hit) begin
      best     <= mag;
      best_new <= is_new;
      best_alt <= ent_alt;
    end
  end

  assign res.done   = done;
  assign res.found  = best < DW'(dse_pkg::MAX_LOOKUP_MS);
  assign res.is_new = best_new;
  assign res.alt    = best_alt;

endmodule

[design/delayed_sensor_emulator_top.sv]
// Delayed barometric altitude emulator.
// meas (valid/ready sink) takes one word per update: now_ms, true_altitude and
// a Q1.15 noise_sample. report (valid/ready source) gives at most one word,
// reported_altitude, per update. Words that arrive while the sensor is absent or
// disabled, or less than 12 ms after the last taken update, are consumed and
// give nothing.
// A taken update forms altitude + drift + scaled noise + glitch offset, stores it
// with its timestamp every 10 ms in a ring buffer, and reports the buffer entry
// closest to now_ms - delay_ms when within 200 ms, else the fresh value.
// The scan of the buffer memory, one entry per cycle, is the longer path from
// acceptance to report.valid. The drift and noise arithmetic (seven steps) runs
// alongside the scan. One update is in flight at a time; meas.ready is high
// only between updates, so the next update is not taken before this one ends.
// A finished word waits in the report register; the next update is taken
// meanwhile, and it stalls at its end only if that register is still full.
// Reset (rst, synchronous) restores the registers to their defaults, clears the
// time and index state and marks every buffer entry empty. Configuration is
// written through cfg_write / cfg_index / cfg_data; the user is to write it
// between updates, which the block itself does not enforce.
module delayed_sensor_emulator_top #(
  parameter int BUFFER_DEPTH = dse_pkg::BUFFER_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  dse_meas_if.sink                             meas,
  dse_report_if.source                         report,
  input  logic                                 cfg_write,
  input  logic [dse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dse_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int TW = dse_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;

  logic                                sensor_present;
  logic                                disable_cfg;
  logic signed [dse_pkg::DRIFT_W-1:0]  drift_rate;
  logic        [dse_pkg::AMP_W-1:0]    noise_amplitude;
  logic signed [dse_pkg::ALT_W-1:0]    glitch_offset;
  logic        [dse_pkg::DELAY_W-1:0]  delay_ms;

  logic [TW-1:0]                       last_update_time;
  logic [TW-1:0]                       last_store_time;
  logic [IW-1:0]                       write_index;

  logic                                go;
  logic                                store;
  logic [TW-1:0]                       now;
  logic [TW-1:0]                       target;
  logic signed [dse_pkg::ALT_W-1:0]    alt;
  logic signed [dse_pkg::NOISE_W-1:0]  noise;

  logic                                out_valid;
  logic [dse_pkg::ALT_W-1:0]           out_data;

  dse_pkg::calc_cfg_t                  calc_cfg;
  dse_pkg::calc_res_t                  calc_res;
  dse_pkg::srch_res_t                  srch_res;

  logic                                accept;
  logic                                active;
  logic                                slot_free;
  logic                                finish;
  logic                                wr_en;
  logic [dse_pkg::ALT_W-1:0]           result;

  assign meas.ready = (state == S_IDLE);
  assign accept     = meas.valid && meas.ready;
  assign active     = sensor_present && !disable_cfg &&
                      ((meas.now_ms - last_update_time) >= TW'(dse_pkg::MIN_UPDATE_MS));
  assign slot_free  = !out_valid || report.ready;
  assign finish     = (state == S_FIN) && slot_free;
  assign wr_en      = finish && store;
  assign result     = (srch_res.found && !srch_res.is_new) ? srch_res.alt : calc_res.value;

  assign calc_cfg.drift_rate      = drift_rate;
  assign calc_cfg.noise_amplitude = noise_amplitude;
  assign calc_cfg.glitch_offset   = glitch_offset;

  assign report.valid             = out_valid;
  assign report.reported_altitude = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_present  <= 1'b1;
      disable_cfg     <= 1'b0;
      drift_rate      <= '0;
      noise_amplitude <= '0;
      glitch_offset   <= '0;
      delay_ms        <= '0;
    end else if (cfg_write) begin
      unique case (dse_pkg::cfg_reg_t'(cfg_index))
        dse_pkg::REG_SENSOR_PRESENT:  sensor_present  <= cfg_data[0];
        dse_pkg::REG_DISABLE:         disable_cfg     <= cfg_data[0];
        dse_pkg::REG_DRIFT_RATE:      drift_rate      <= cfg_data[dse_pkg::DRIFT_W-1:0];
        dse_pkg::REG_NOISE_AMPLITUDE: noise_amplitude <= cfg_data[dse_pkg::AMP_W-1:0];
        dse_pkg::REG_GLITCH_OFFSET:   glitch_offset   <= cfg_data[dse_pkg::ALT_W-1:0];
        dse_pkg::REG_DELAY_MS:        delay_ms        <= cfg_data[dse_pkg::DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      go               <= 1'b0;
      store            <= 1'b0;
      last_update_time <= '0;
      last_store_time  <= '0;
      write_index      <= '0;
      out_valid        <= 1'b0;
    end else begin
      go        <= accept && active;
      out_valid <= finish || (out_valid && !report.ready);
      unique case (state)
        S_IDLE: begin
          if (accept && active) begin
            last_update_time <= meas.now_ms;
            store <= (meas.now_ms - last_store_time) >= TW'(dse_pkg::STORE_PERIOD_MS);
            if ((meas.now_ms - last_store_time) >= TW'(dse_pkg::STORE_PERIOD_MS)) begin
              last_store_time <= meas.now_ms;
            end
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (!go && calc_res.done && srch_res.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (store) begin
              write_index <= (write_index == IW'(BUFFER_DEPTH - 1)) ? '0 :
                             write_index + IW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now    <= meas.now_ms;
      target <= meas.now_ms - TW'(delay_ms);
      alt    <= meas.true_altitude;
      noise  <= meas.noise_sample;
    end
    if (finish) begin
      out_data <= result;
    end
  end

  dse_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .cfg   (calc_cfg),
    .now   (now),
    .alt   (alt),
    .noise (noise),
    .res   (calc_res)
  );

  dse_buf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk    (clk),
    .rst    (rst),
    .start  (go),
    .target (target),
    .now    (now),
    .store  (store),
    .w_idx  (write_index),
    .wr_en  (wr_en),
    .wr_alt (calc_res.value),
    .res    (srch_res)
  );

  a_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    go |=> !calc_res.done && !srch_res.done)
    else $error("unit done flag survived a new start");

  a_report_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> $past(state == S_FIN))
    else $error("report word loaded outside the finish step");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    write_index <= IW'(BUFFER_DEPTH - 1))
    else $error("ring write index beyond buffer depth");

  a_go_after_update: assert property (@(posedge clk) disable iff (rst)
    accept && active |=> go && (state == S_BUSY))
    else $error("taken update did not start the units");

endmodule
